>>> sv/sst_pkg.sv
// Shared types and constants for the sorted set table.
package sst_pkg;

   localparam int CAPACITY_DEF = 16;

   localparam int OP_W      = 3;
   localparam int VAL_W     = 8;
   localparam int IDX_W     = 4;
   localparam int CNT_OUT_W = 5;
   localparam int ST_W      = 2;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 3'd0,
      OP_INSERT = 3'd1,
      OP_REMOVE = 3'd2,
      OP_MEMBER = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_ABSENT = 2'd2,
      ST_RANGE  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_READ,
      S_DONE
   } state_type;

endpackage

>>> sv/sst_if.sv
// Request and response channel interfaces for the sorted set table.
interface sst_req_if;
   logic                         valid;
   logic                         ready;
   logic [sst_pkg::OP_W-1:0]     op;
   logic [sst_pkg::VAL_W-1:0]    value;
   logic [sst_pkg::IDX_W-1:0]    index;

   modport source (output valid, output op, output value, output index, input ready);
   modport sink   (input valid, input op, input value, input index, output ready);
endinterface

interface sst_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic [sst_pkg::VAL_W-1:0]     element;
   logic [sst_pkg::CNT_OUT_W-1:0] count;
   logic [sst_pkg::ST_W-1:0]      status;

   modport source (output valid, output found, output element, output count, output status,
                   input ready);
   modport sink   (input valid, input found, input element, input count, input status,
                   output ready);
endinterface

>>> sv/sst_store.sv
// Element store: one write port, one read port with registered read data.
module sst_store #(
   parameter int DEPTH = sst_pkg::CAPACITY_DEF,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [sst_pkg::VAL_W-1:0]   wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [sst_pkg::VAL_W-1:0]   rd_data
);

   logic [sst_pkg::VAL_W-1:0] mem_ff [DEPTH];
   logic [sst_pkg::VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/sorted_set_table.sv
// Sorted set table: ordered set of distinct bytes kept in a one-port-read memory.
//
//   channel   direction  contents                              transaction when
//   req_ch    in         op, value, index                      valid && ready
//   rsp_ch    out        found, element, count, status         valid && ready
//
// Clear, unused op codes and out-of-range read go from accept straight to the done state;
// read passes the read state first. Member, insert and remove walk the memory from entry
// 0 at one entry per cycle, compared in the cycle after the read, until an entry >= value
// or the end of the set. Insert then moves the displaced entries top first and remove
// bottom first, one per cycle, draining the read before the done state.
// Synchronous reset empties the set at once; stale entries are never read, so no
// clearing pass runs. req_ch.ready is high only in idle; a waiting response holds
// in the output register while the next request is already being served.
module sorted_set_table #(
   parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sst_req_if.sink     req_ch,
   sst_rsp_if.source   rsp_ch
);

   localparam int AW     = $clog2(CAPACITY);
   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int IW     = sst_pkg::IDX_W;
   localparam int XW     = (CW > IW) ? CW : IW;
   localparam int COUT_W = sst_pkg::CNT_OUT_W;
   localparam int VW     = sst_pkg::VAL_W;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   // control state
   sst_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                cmp_vld_ff, cmp_vld_in;   // read data holds entry ptr_ff - 1
   logic                shv_ff, shv_in;           // read data waits to be written back

   // working registers
   logic [sst_pkg::OP_W-1:0]  op_ff, op_in;
   logic [VW-1:0]             value_ff, value_in;
   logic [CW-1:0]             ptr_ff, ptr_in;
   logic [CW-1:0]             rem_ff, rem_in;
   logic [CW-1:0]             pos_ff, pos_in;
   logic                      up_ff, up_in;
   logic [AW-1:0]             wr_addr_ff, wr_addr_in;
   logic                      res_found_ff, res_found_in;
   sst_pkg::status_type       res_status_ff, res_status_in;

   // response register
   logic                      rsp_found_ff, rsp_found_in;
   logic [VW-1:0]             rsp_element_ff, rsp_element_in;
   logic [COUT_W-1:0]         rsp_count_ff, rsp_count_in;
   sst_pkg::status_type       rsp_status_ff, rsp_status_in;

   // memory port
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [VW-1:0]   wr_data;
   logic [AW-1:0]   rd_addr;
   logic [VW-1:0]   rd_data;

   logic            accept;
   logic            rsp_free;
   logic            idx_ok;
   logic            scan_ge, scan_end, scan_done, scan_hit;
   logic [CW-1:0]   scan_pos;
   logic            shift_go;
   logic            shift_last;

   sst_store #(.DEPTH(CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ch.ready   = (state_ff == sst_pkg::S_IDLE);
   assign accept         = req_ch.valid && req_ch.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_ch.ready;
   assign idx_ok         = XW'(req_ch.index) < XW'(count_ff);
   assign rd_addr        = ptr_ff[AW-1:0];

   // The walk stops at the first entry not below the value, or at the end of the set.
   assign scan_ge    = cmp_vld_ff && (rd_data >= value_ff);
   assign scan_end   = !scan_ge && (ptr_ff >= count_ff);
   assign scan_done  = scan_ge || scan_end;
   assign scan_hit   = scan_ge && (rd_data == value_ff);
   assign scan_pos   = scan_ge ? (ptr_ff - ONE_C) : count_ff;
   assign shift_go   = ((op_ff == sst_pkg::OP_INSERT) && !scan_hit && (count_ff != CAP_C)) ||
                       ((op_ff == sst_pkg::OP_REMOVE) && scan_hit);
   assign shift_last = (rem_ff == '0) && !shv_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sst_pkg::S_IDLE: begin
            if (accept) begin
               case (req_ch.op)
                  sst_pkg::OP_INSERT,
                  sst_pkg::OP_REMOVE,
                  sst_pkg::OP_MEMBER: state_in = sst_pkg::S_SCAN;
                  sst_pkg::OP_READ:   state_in = idx_ok ? sst_pkg::S_READ : sst_pkg::S_DONE;
                  default:            state_in = sst_pkg::S_DONE;
               endcase
            end
         end
         sst_pkg::S_SCAN: begin
            if (scan_done) begin
               state_in = shift_go ? sst_pkg::S_SHIFT : sst_pkg::S_DONE;
            end
         end
         sst_pkg::S_SHIFT: begin
            if (shift_last) begin
               state_in = sst_pkg::S_DONE;
            end
         end
         sst_pkg::S_READ: state_in = sst_pkg::S_DONE;
         sst_pkg::S_DONE: begin
            if (rsp_free) begin
               state_in = sst_pkg::S_IDLE;
            end
         end
         default: state_in = sst_pkg::S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in       = count_ff;
      cmp_vld_in     = cmp_vld_ff;
      shv_in         = shv_ff;
      op_in          = op_ff;
      value_in       = value_ff;
      ptr_in         = ptr_ff;
      rem_in         = rem_ff;
      pos_in         = pos_ff;
      up_in          = up_ff;
      wr_addr_in     = wr_addr_ff;
      res_found_in   = res_found_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_found_in   = rsp_found_ff;
      rsp_element_in = rsp_element_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_status_in  = rsp_status_ff;
      wr_en          = 1'b0;
      wr_addr        = wr_addr_ff;
      wr_data        = rd_data;

      case (state_ff)
         sst_pkg::S_IDLE: begin
            if (accept) begin
               // capture the request and reset the walk
               op_in         = req_ch.op;
               value_in      = req_ch.value;
               ptr_in        = '0;
               cmp_vld_in    = 1'b0;
               res_found_in  = 1'b0;
               res_status_in = sst_pkg::ST_OK;
               case (req_ch.op)
                  sst_pkg::OP_CLEAR: count_in = '0;
                  sst_pkg::OP_READ: begin
                     if (idx_ok) begin
                        ptr_in = CW'(req_ch.index);
                     end else begin
                        res_status_in = sst_pkg::ST_RANGE;
                     end
                  end
                  default: ;
               endcase
            end
         end

         sst_pkg::S_SCAN: begin
            if (!scan_done) begin
               // advance one entry per cycle; the compare sees it in the next cycle
               cmp_vld_in = ptr_ff < count_ff;
               if (ptr_ff < count_ff) begin
                  ptr_in = ptr_ff + ONE_C;
               end
            end else begin
               cmp_vld_in = 1'b0;
               shv_in     = 1'b0;
               pos_in     = scan_pos;
               case (op_ff)
                  sst_pkg::OP_MEMBER: begin
                     res_found_in  = scan_hit;
                     res_status_in = scan_hit ? sst_pkg::ST_OK : sst_pkg::ST_ABSENT;
                  end
                  sst_pkg::OP_INSERT: begin
                     if (scan_hit) begin
                        res_found_in = 1'b1;
                     end else if (count_ff == CAP_C) begin
                        res_status_in = sst_pkg::ST_FULL;
                     end else begin
                        // move entries pos..count-1 up one, top first
                        up_in  = 1'b1;
                        rem_in = count_ff - scan_pos;
                        ptr_in = count_ff - ONE_C;
                     end
                  end
                  sst_pkg::OP_REMOVE: begin
                     if (scan_hit) begin
                        // move entries pos+1..count-1 down one, bottom first
                        res_found_in = 1'b1;
                        up_in        = 1'b0;
                        rem_in       = count_ff - scan_pos - ONE_C;
                        ptr_in       = scan_pos + ONE_C;
                     end else begin
                        res_status_in = sst_pkg::ST_ABSENT;
                     end
                  end
                  default: ;
               endcase
            end
         end

         sst_pkg::S_SHIFT: begin
            // write back the entry read last cycle to its neighbor slot
            wr_en = shv_ff;
            if (rem_ff != '0) begin
               ptr_in     = up_ff ? (ptr_ff - ONE_C) : (ptr_ff + ONE_C);
               rem_in     = rem_ff - ONE_C;
               shv_in     = 1'b1;
               wr_addr_in = up_ff ? AW'(ptr_ff + ONE_C) : AW'(ptr_ff - ONE_C);
            end else begin
               shv_in = 1'b0;
            end
            if (shift_last) begin
               if (up_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = pos_ff[AW-1:0];
                  wr_data  = value_ff;
                  count_in = count_ff + ONE_C;
               end else begin
                  count_in = count_ff - ONE_C;
               end
            end
         end

         sst_pkg::S_DONE: begin
            // hold until the output register is free, then hand the result over
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_found_in   = res_found_ff;
               rsp_element_in = ((op_ff == sst_pkg::OP_READ) &&
                                 (res_status_ff == sst_pkg::ST_OK)) ? rd_data : '0;
               rsp_count_in   = COUT_W'(count_ff);
               rsp_status_in  = res_status_ff;
            end
         end

         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sst_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         shv_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_vld_ff   <= cmp_vld_in;
         shv_ff       <= shv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      value_ff       <= value_in;
      ptr_ff         <= ptr_in;
      rem_ff         <= rem_in;
      pos_ff         <= pos_in;
      up_ff          <= up_in;
      wr_addr_ff     <= wr_addr_in;
      res_found_ff   <= res_found_in;
      res_status_ff  <= res_status_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_element_ff <= rsp_element_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.found   = rsp_found_ff;
   assign rsp_ch.element = rsp_element_ff;
   assign rsp_ch.count   = rsp_count_ff;
   assign rsp_ch.status  = rsp_status_ff;

`ifndef ASSERT_OFF
   // The set never holds more entries than the store has.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("element count exceeds capacity");

   // The store is written only while a transaction is in work.
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sst_pkg::S_IDLE) |-> !wr_en)
      else $error("memory write while idle");

   // An accepted request always leaves idle on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != sst_pkg::S_IDLE))
      else $error("accepted request did not start");

   // A refused insert only happens with a full store.
   a_full_refuse: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == sst_pkg::S_DONE) && (res_status_ff == sst_pkg::ST_FULL))
         |-> (count_ff == CAP_C))
      else $error("full status with room left");
`endif

endmodule

>>> verif/tb_sorted_set_table.sv
// Self-checking testbench for the sorted set table: random traffic with a shadow set.
module tb_sorted_set_table;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SET_CAP = sst_pkg::CAPACITY_DEF;

   // Op codes 5..7 are not decoded by the block; they must act as a no-op.
   localparam logic [sst_pkg::OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
   localparam logic [sst_pkg::OP_W-1:0] OP_MID_UNUSED   = 3'd6;
   localparam logic [sst_pkg::OP_W-1:0] OP_LAST_UNUSED  = 3'd7;

   // Total input transactions, directed part included.
   localparam int ITEM_TOTAL = 1450;

   // Cycles without any transaction on either channel before the run is
   // declared hung. The slowest legal spacing is the longest sender gap, a
   // full table walk and shift, and the longest receiver stall.
   localparam int HANG_LIMIT = 2000;

   // Cycles to keep watching after the last response, for stray responses.
   localparam int DRAIN_CYCLES = 60;

   // One predicted response, tagged with the op that caused it.
   typedef struct packed {
      logic [sst_pkg::OP_W-1:0]      op;
      logic                          found;
      logic [sst_pkg::VAL_W-1:0]     element;
      logic [sst_pkg::CNT_OUT_W-1:0] count;
      sst_pkg::status_type           status;
   } outcome_type;

   // Shadow copy of the set plus the queue of responses still owed by the block.
   class sorted_set_ledger;
      logic [sst_pkg::VAL_W-1:0] members [SET_CAP];
      int unsigned               population;
      outcome_type               owed_outcomes[$];
      int unsigned               mismatches;

      function new();
         population  = 0;
         mismatches  = 0;
      endfunction

      // Work out the response to one accepted request and advance the shadow set.
      function void log_request(logic [sst_pkg::OP_W-1:0] op,
                                logic [sst_pkg::VAL_W-1:0] value,
                                logic [sst_pkg::IDX_W-1:0] index);
         outcome_type res;
         int unsigned pos;
         bit          hit;
         res         = '0;
         res.op      = op;
         res.status  = sst_pkg::ST_OK;
         pos         = 0;
         while (pos < population && members[pos] < value) pos++;
         hit = (pos < population) && (members[pos] == value);
         case (op)
            sst_pkg::OP_CLEAR: begin
               population = 0;
            end
            sst_pkg::OP_INSERT: begin
               if (hit) begin
                  res.found = 1'b1;
               end else if (population >= SET_CAP) begin
                  res.status = sst_pkg::ST_FULL;
               end else begin
                  for (int k = population; k > pos; k--) members[k] = members[k-1];
                  members[pos] = value;
                  population++;
               end
            end
            sst_pkg::OP_REMOVE: begin
               if (hit) begin
                  res.found = 1'b1;
                  for (int k = pos; k + 1 < population; k++) members[k] = members[k+1];
                  population--;
               end else begin
                  res.status = sst_pkg::ST_ABSENT;
               end
            end
            sst_pkg::OP_MEMBER: begin
               if (hit) res.found = 1'b1;
               else res.status = sst_pkg::ST_ABSENT;
            end
            sst_pkg::OP_READ: begin
               if (index < population) res.element = members[index];
               else res.status = sst_pkg::ST_RANGE;
            end
            default: begin
            end
         endcase
         res.count = sst_pkg::CNT_OUT_W'(population);
         owed_outcomes.push_back(res);
      endfunction

      task flag_mismatch(string what, int got, int want, logic [sst_pkg::OP_W-1:0] op);
         mismatches++;
         $display("[%0t] mismatch on %s: got %0d, want %0d (op %0d)",
                  $realtime, what, got, want, op);
      endtask

      // Compare one accepted response against the oldest owed one.
      task check_outcome(logic found, logic [sst_pkg::VAL_W-1:0] element,
                         logic [sst_pkg::CNT_OUT_W-1:0] count,
                         logic [sst_pkg::ST_W-1:0] status);
         outcome_type want;
         if (owed_outcomes.size() == 0) begin
            flag_mismatch("response with nothing owed", 1, 0, '0);
         end else begin
            want = owed_outcomes.pop_front();
            if (found !== want.found)
               flag_mismatch("found", found, want.found, want.op);
            if (element !== want.element)
               flag_mismatch("element", element, want.element, want.op);
            if (count !== want.count)
               flag_mismatch("count", count, want.count, want.op);
            if (status !== want.status)
               flag_mismatch("status", status, want.status, want.op);
         end
      endtask
   endclass

   logic clock;
   logic reset;

   sst_req_if req_ch ();
   sst_rsp_if rsp_ch ();

   sorted_set_table #(.CAPACITY(SET_CAP)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   sorted_set_ledger ledger = new();

   // When set, both sides run back to back with no idle cycles.
   bit steady_flow;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Idle cycles before the next transaction on either side. Roughly a third
   // of draws are zero so short bursts appear even in idling stretches.
   function automatic int draw_wait();
      if (steady_flow) return 0;
      return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 18));
   endfunction

   // Drive one request after a random gap and hold it until the block takes it.
   // Valid is only dropped when a gap follows, so it is never lowered and
   // raised again in one time step.
   task automatic issue_request(input logic [sst_pkg::OP_W-1:0] op,
                                input logic [sst_pkg::VAL_W-1:0] value,
                                input logic [sst_pkg::IDX_W-1:0] index);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op    <= op;
      req_ch.value <= value;
      req_ch.index <= index;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   // Response side: stall a random number of cycles, then accept one
   // transaction. Ready stays high across back-to-back accepts.
   initial begin : rsp_pacer
      int stall;
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
      end
   end

   // Monitor both channels at the clock edge. A request and a response taken
   // on the same edge do not interact: the response belongs to an older request.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            ledger.log_request(req_ch.op, req_ch.value, req_ch.index);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            ledger.check_outcome(rsp_ch.found, rsp_ch.element, rsp_ch.count, rsp_ch.status);
      end
   end

   // Hang detector: count edges with no transaction on either channel.
   initial begin : hang_watch
      int quiet_cycles;
      quiet_cycles = 0;
      wait (reset === 1'b0);
      while (quiet_cycles < HANG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("[%0t] no transaction for %0d cycles, %0d responses owed",
               $realtime, HANG_LIMIT, ledger.owed_outcomes.size());
      $display("tb_sorted_set_table NOT OK");
      $finish;
   end

   initial begin : stimulus
      int          items_sent;
      int          kind;
      int          episode_len;
      int          roll;
      int          t_clear, t_unused, t_ins, t_rem, t_mem;
      bit          narrow;
      int          pool_base;
      logic [sst_pkg::OP_W-1:0]  op;
      logic [sst_pkg::VAL_W-1:0] value;
      logic [sst_pkg::IDX_W-1:0] index;

      items_sent   = 0;
      steady_flow  = 1'b0;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.op    <= sst_pkg::OP_CLEAR;
      req_ch.value <= '0;
      req_ch.index <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty-set cases first, then both value extremes,
      // a duplicate insert, hits and misses, reads at and past the count,
      // the unused op codes, and clear.
      issue_request(sst_pkg::OP_READ,   8'h00, 4'd0);    // read on an empty set
      issue_request(sst_pkg::OP_MEMBER, 8'h55, 4'd0);    // query on an empty set
      issue_request(sst_pkg::OP_REMOVE, 8'hAA, 4'd15);   // remove of an absent value
      issue_request(sst_pkg::OP_INSERT, 8'h80, 4'd0);
      issue_request(sst_pkg::OP_INSERT, 8'h00, 4'd0);    // lowest value goes to the front
      issue_request(sst_pkg::OP_INSERT, 8'hFF, 4'd0);    // highest value goes to the back
      issue_request(sst_pkg::OP_INSERT, 8'h80, 4'd0);    // duplicate changes nothing
      issue_request(sst_pkg::OP_MEMBER, 8'hFF, 4'd0);
      issue_request(sst_pkg::OP_MEMBER, 8'h7F, 4'd0);    // neighbor of a member is absent
      issue_request(sst_pkg::OP_READ,   8'h00, 4'd0);
      issue_request(sst_pkg::OP_READ,   8'h00, 4'd2);    // last valid index
      issue_request(sst_pkg::OP_READ,   8'h00, 4'd3);    // index equal to count
      issue_request(sst_pkg::OP_READ,   8'hFF, 4'd15);   // top index
      issue_request(sst_pkg::OP_REMOVE, 8'h00, 4'd0);    // remove from the front
      issue_request(sst_pkg::OP_REMOVE, 8'h01, 4'd0);
      issue_request(sst_pkg::OP_READ,   8'h00, 4'd0);
      issue_request(sst_pkg::OP_REMOVE, 8'hFF, 4'd0);    // remove from the back
      issue_request(OP_FIRST_UNUSED, 8'hFF, 4'd15);
      issue_request(OP_MID_UNUSED, 8'h5A, 4'd9);
      issue_request(OP_LAST_UNUSED, 8'h00, 4'd0);
      issue_request(sst_pkg::OP_CLEAR,  8'hFF, 4'd15);
      issue_request(sst_pkg::OP_READ,   8'h00, 4'd0);    // read after clear
      issue_request(sst_pkg::OP_MEMBER, 8'h80, 4'd0);    // cleared value is gone
      items_sent = 23;

      // Random part, in episodes. Each episode leans toward growing,
      // shrinking, querying or churning the set, and usually draws values
      // from a narrow window so that hits, duplicates and a full set are common.
      while (items_sent < ITEM_TOTAL) begin
         kind        = $urandom_range(0, 3);
         steady_flow = ($urandom_range(0, 3) == 0);
         narrow      = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 3))
            0:       pool_base = 0;
            1:       pool_base = 232;
            default: pool_base = $urandom_range(0, 232);
         endcase
         case (kind)
            0:       begin t_clear = 1; t_unused = 2; t_ins = 70; t_rem = 80; t_mem = 90; end
            1:       begin t_clear = 1; t_unused = 2; t_ins = 15; t_rem = 65; t_mem = 80; end
            2:       begin t_clear = 1; t_unused = 2; t_ins = 15; t_rem = 25; t_mem = 60; end
            default: begin t_clear = 3; t_unused = 5; t_ins = 40; t_rem = 70; t_mem = 85; end
         endcase
         episode_len = $urandom_range(20, 60);
         for (int k = 0; k < episode_len && items_sent < ITEM_TOTAL; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < t_clear)       op = sst_pkg::OP_CLEAR;
            else if (roll < t_unused) op = sst_pkg::OP_W'($urandom_range(OP_FIRST_UNUSED,
                                                                        OP_LAST_UNUSED));
            else if (roll < t_ins)    op = sst_pkg::OP_INSERT;
            else if (roll < t_rem)    op = sst_pkg::OP_REMOVE;
            else if (roll < t_mem)    op = sst_pkg::OP_MEMBER;
            else                      op = sst_pkg::OP_READ;
            value = narrow ? sst_pkg::VAL_W'(pool_base + $urandom_range(0, 23))
                           : sst_pkg::VAL_W'($urandom_range(0, 255));
            // Aim half the reads inside the current set; the rest anywhere.
            if ($urandom_range(0, 1) == 0 && ledger.population > 0)
               index = sst_pkg::IDX_W'($urandom_range(0, ledger.population - 1));
            else
               index = sst_pkg::IDX_W'($urandom_range(0, 15));
            issue_request(op, value, index);
            items_sent++;
         end
      end
      req_ch.valid <= 1'b0;
      steady_flow  = 1'b0;

      // Drain: wait for every owed response, then watch for strays.
      while (ledger.owed_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (ledger.mismatches == 0)
         $display("tb_sorted_set_table OK");
      else
         $display("tb_sorted_set_table NOT OK");
      $finish;
   end

endmodule

>>> sorted_set_table.f
sv/sst_pkg.sv
sv/sst_if.sv
sv/sst_store.sv
sv/sorted_set_table.sv
verif/tb_sorted_set_table.sv
